// File: rtl/core/clook_disk_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the C-LOOK disk scheduler
// Shared helpers that wrap a concurrent assertion with clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef CLOOK_DISK_SCHEDULER_DEFINES_SVH
`define CLOOK_DISK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLOOK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLOOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/clook_pkg.sv
// ----------------------------------------------------------------------------
// clook_pkg
// Types and constants shared by the C-LOOK scheduler modules.
// ----------------------------------------------------------------------------
package clook_pkg;

    localparam int MAX_REQUESTS = 64;
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int CYL_W        = 16;
    localparam int TOT_W        = 24;

    // Command codes of an input word.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // One cell of the request chain: the cylinder and whether it lies below the head.
    typedef struct packed {
        logic             lo;
        logic [CYL_W-1:0] val;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,
        OP_MARK,
        OP_SORT,
        OP_POP
    } t_cell_op;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cell_op         op;
        logic [CYL_W-1:0] head;
        logic             parity;
        logic [CNT_W-1:0] cnt;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/core/clook_if.sv
// ----------------------------------------------------------------------------
// clook_req_if / clook_res_if
// Valid/ready channels for request words and scheduled result words.
// ----------------------------------------------------------------------------
interface clook_req_if import clook_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [CYL_W-1:0] cylinder;

    modport source (output valid, output cmd, output cylinder, input ready);
    modport sink   (input valid, input cmd, input cylinder, output ready);
endinterface

interface clook_res_if import clook_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] served_cylinder;
    logic [TOT_W-1:0] total_movement;
    logic             empty_run;
    logic             last;

    modport source (output valid, output served_cylinder, output total_movement,
                    output empty_run, output last, input ready);
    modport sink   (input valid, input served_cylinder, input total_movement,
                    input empty_run, input last, output ready);
endinterface

// File: rtl/core/clook_cell.sv
// ----------------------------------------------------------------------------
// clook_cell
// One request cell: shifts in loads, marks itself against the head, takes part
// in odd-even transposition sorting with its neighbors and shifts out results.
// ----------------------------------------------------------------------------
module clook_cell import clook_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_index,
    input  t_entry           i_left,
    input  t_entry           i_right,
    output t_entry           o_entry
);

    t_entry           r_entry;
    t_entry           n_entry;
    logic             w_is_lower;
    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_pos_next;

    assign w_pos      = CNT_W'(i_index);
    assign w_pos_next = w_pos + CNT_W'(1);
    // In an even phase the pairs start at even cells, in an odd phase at odd ones.
    assign w_is_lower = (i_index[0] == i_ctl.parity);

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_SHIFT_IN: begin
                n_entry = i_left;
            end
            OP_MARK: begin
                n_entry.lo = (r_entry.val < i_ctl.head);
            end
            OP_SORT: begin
                if (w_is_lower) begin
                    if (w_pos_next < i_ctl.cnt && r_entry > i_right) begin
                        n_entry = i_right;
                    end
                end else begin
                    if (w_pos < i_ctl.cnt && i_index != '0 && i_left > r_entry) begin
                        n_entry = i_left;
                    end
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/core/clook_disk_scheduler.sv
// ----------------------------------------------------------------------------
// clook_disk_scheduler
// C-LOOK seek ordering of pending cylinder requests with running head movement.
// ----------------------------------------------------------------------------
// Request words arrive on i_req. A word with cmd LOAD pushes its cylinder into
// a chain of 64 cells; once 64 requests are pending, further loads are
// accepted and dropped. A word with cmd START carries the head position and
// launches a run. Every cell then marks whether its request lies below the
// head, and the chain sorts itself by odd-even transposition on the key
// {below head, cylinder}, one phase per cycle, 64 phases in all. The cells
// then shift their contents toward cell 0, one result word per cycle on o_res
// while the receiver is ready, each with the running total of absolute head
// movement. A start with no pending requests yields a single word marked
// empty_run. A start with n pending requests runs the 64 sorting phases
// before its first result word and then one pop per request; an empty start
// goes straight to its single word. Loads are taken only while no run is in
// progress. The result sits in an output register, so new loads are accepted
// while the last word of a run still waits. When the receiver stalls, the
// chain holds and the register keeps its word. Reset clears the pending count
// and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module clook_disk_scheduler import clook_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    clook_req_if.sink      i_req,
    clook_res_if.source    o_res
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_run_cnt;
    logic [CNT_W-1:0] r_left;
    logic [IDX_W-1:0] r_phase;
    logic [CYL_W-1:0] r_head;
    logic [TOT_W-1:0] r_total;
    logic             r_empty;

    logic             r_ovalid;
    logic [CYL_W-1:0] r_ocyl;
    logic [TOT_W-1:0] r_ototal;
    logic             r_oempty;
    logic             r_olast;

    t_cell_ctl        w_ctl;
    t_entry           w_entry [MAX_REQUESTS];
    logic             w_in_acc;
    logic             w_take;
    logic             w_last;
    logic             w_ready;
    logic [CYL_W-1:0] w_dist;
    logic [CYL_W-1:0] w_val;

    assign w_in_acc = i_req.valid && w_ready;
    assign w_take   = !r_ovalid || o_res.ready;
    assign w_val    = w_entry[0].val;
    assign w_dist   = (r_head > w_val) ? (r_head - w_val) : (w_val - r_head);
    assign w_last   = (r_left == CNT_W'(1));

    // The chain of cells.
    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = '{lo: 1'b0, val: i_req.cylinder};
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == MAX_REQUESTS - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        clook_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g])
        );
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_req.cmd == CMD_START) begin
                    n_state = (r_count == '0) ? ST_EMIT : ST_SORT;
                end
            end
            ST_SORT: begin
                if (r_phase == IDX_W'(MAX_REQUESTS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_take && (r_empty || w_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake and the control broadcast to the cells.
    always_comb begin
        w_ready    = 1'b0;
        w_ctl.op   = OP_HOLD;
        w_ctl.head = i_req.cylinder;
        w_ctl.parity = r_phase[0];
        w_ctl.cnt  = r_run_cnt;
        case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                if (w_in_acc) begin
                    if (i_req.cmd == CMD_START) begin
                        w_ctl.op = OP_MARK;
                    end else if (r_count < CNT_W'(MAX_REQUESTS)) begin
                        w_ctl.op = OP_SHIFT_IN;
                    end
                end
            end
            ST_SORT: begin
                w_ctl.op = OP_SORT;
            end
            ST_EMIT: begin
                if (w_take && !r_empty) begin
                    w_ctl.op = OP_POP;
                end
            end
            default: begin
                w_ctl.op = OP_HOLD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_in_acc) begin
                if (i_req.cmd == CMD_START) begin
                    r_count <= '0;
                end else if (r_count < CNT_W'(MAX_REQUESTS)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (r_state == ST_SORT) begin
                r_phase <= r_phase + IDX_W'(1);
            end else begin
                r_phase <= '0;
            end
            if (r_state == ST_EMIT && w_take) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Run and result data.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc && i_req.cmd == CMD_START) begin
            r_head    <= i_req.cylinder;
            r_run_cnt <= r_count;
            r_left    <= r_count;
            r_total   <= '0;
            r_empty   <= (r_count == '0);
        end
        if (r_state == ST_EMIT && w_take) begin
            if (r_empty) begin
                r_ocyl   <= '0;
                r_ototal <= '0;
                r_oempty <= 1'b1;
                r_olast  <= 1'b1;
            end else begin
                r_ocyl   <= w_val;
                r_ototal <= r_total + TOT_W'(w_dist);
                r_oempty <= 1'b0;
                r_olast  <= w_last;
                r_total  <= r_total + TOT_W'(w_dist);
                r_head   <= w_val;
                r_left   <= r_left - CNT_W'(1);
            end
        end
    end

    assign i_req.ready           = w_ready;
    assign o_res.valid           = r_ovalid;
    assign o_res.served_cylinder = r_ocyl;
    assign o_res.total_movement  = r_ototal;
    assign o_res.empty_run       = r_oempty;
    assign o_res.last            = r_olast;

endmodule

// File: rtl/core/clook_chk.sv
// ----------------------------------------------------------------------------
// clook_chk
// Port-level checks of the C-LOOK scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "clook_disk_scheduler_defines.svh"

module clook_chk import clook_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_req_cmd,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [CYL_W-1:0] i_res_cyl,
    input logic [TOT_W-1:0] i_res_total,
    input logic             i_res_empty,
    input logic             i_res_last
);

    `CLOOK_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_cyl) && $stable(i_res_total) && $stable(i_res_last),
        "result word changed while stalled")
    `CLOOK_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, i_res_valid && i_res_empty,
        i_res_last, "empty run word not marked last")
    `CLOOK_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_res_valid && i_res_empty,
        i_res_cyl == '0 && i_res_total == '0, "empty run word carries data")
    `CLOOK_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n,
        i_req_valid && i_req_ready && i_req_cmd == CMD_START,
        !i_req_ready, "request taken right after a start")

endmodule

bind clook_disk_scheduler clook_chk u_clook_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_cmd   (i_req.cmd),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_cyl   (o_res.served_cylinder),
    .i_res_total (o_res.total_movement),
    .i_res_empty (o_res.empty_run),
    .i_res_last  (o_res.last)
);
